@@ hdl/lbt_pkg.sv @@
// Shared types, constants and register indexes for the LED strip bit transposer.
// Depends on nothing; every other file in hdl/ uses it by scoped names.
package lbt_pkg;

   localparam int MAX_COLUMNS       = 1024;
   localparam int MAX_LINES_PER_PIN = 64;
   localparam int STRIP_COUNT       = 8;

   localparam int PIXEL_W    = 24;
   localparam int BYTE_W     = 8;
   localparam int COL_W      = $clog2(MAX_COLUMNS);
   localparam int ROW_W      = $clog2(MAX_LINES_PER_PIN);
   localparam int CFG_COL_W  = 11;
   localparam int CFG_LINE_W = 7;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int BIT_CNT_W  = 5;

   localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(PIXEL_W - 1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES_PER_PIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ROW_FORWARD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_ORDER       = 3'd4;

   typedef enum logic [2:0] {
      ORDER_RGB = 3'd0,
      ORDER_RBG = 3'd1,
      ORDER_GRB = 3'd2,
      ORDER_GBR = 3'd3,
      ORDER_BRG = 3'd4,
      ORDER_BGR = 3'd5
   } color_order_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] strip0_pixel;
      logic [PIXEL_W-1:0] strip1_pixel;
      logic [PIXEL_W-1:0] strip2_pixel;
      logic [PIXEL_W-1:0] strip3_pixel;
      logic [PIXEL_W-1:0] strip4_pixel;
      logic [PIXEL_W-1:0] strip5_pixel;
      logic [PIXEL_W-1:0] strip6_pixel;
      logic [PIXEL_W-1:0] strip7_pixel;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_byte;
      logic [COL_W-1:0]  next_column;
      logic [ROW_W-1:0]  next_row;
      logic              frame_done;
   } rsp_type;

   typedef struct packed {
      logic [CFG_COL_W-1:0]  column_count;
      logic [CFG_LINE_W-1:0] lines_per_pin;
      logic                  first_row_forward;
      logic [BYTE_W-1:0]     brightness_offset;
      logic [2:0]            color_order;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] next_column;
      logic [ROW_W-1:0] next_row;
      logic             frame_done;
   } pos_type;

   // datapath control from the top level to lanes and merge stage
   typedef struct packed {
      logic capture;  // request accepted into the lane stage
      logic load;     // lane stage moves into the shift stage
      logic shift;    // one byte leaves the shift stage
      logic last;     // that byte is the final one of the position
   } ctl_type;

endpackage

@@ hdl/led_strip_bit_transposer.sv @@
// A request passes the lane hold, shift and response registers before its first byte is
// valid. One byte per cycle goes out while the receiver is ready, set by the shift stage
// that emits the 24 color bits; the next request is taken while this one shifts out.
// Reset: synchronous, active high; clears pipeline valids, byte counter and position
// to column 0 / row 0, and loads register reset values 1, 1, 1, 255, 0.
module led_strip_bit_transposer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lbt_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lbt_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [lbt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lbt_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   lbt_pkg::cfg_type cfg_ff, cfg_in;
   logic             lane_valid_ff, lane_valid_in;
   logic             shift_valid_ff, shift_valid_in;
   logic [lbt_pkg::BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_free, shift_fire, shift_last, shift_free, shift_load, req_fire;
   lbt_pkg::ctl_type ctl;
   lbt_pkg::pos_type pos;
   logic [lbt_pkg::PIXEL_W-1:0]     pixels [lbt_pkg::STRIP_COUNT];
   logic [lbt_pkg::STRIP_COUNT-1:0] lane_bits;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lbt_pkg::CSR_COLUMN_COUNT:
               cfg_in.column_count = csr_wdata[lbt_pkg::CFG_COL_W-1:0];
            lbt_pkg::CSR_LINES_PER_PIN:
               cfg_in.lines_per_pin = csr_wdata[lbt_pkg::CFG_LINE_W-1:0];
            lbt_pkg::CSR_FIRST_ROW_FORWARD:
               cfg_in.first_row_forward = csr_wdata[0];
            lbt_pkg::CSR_BRIGHTNESS_OFFSET:
               cfg_in.brightness_offset = csr_wdata[lbt_pkg::BYTE_W-1:0];
            lbt_pkg::CSR_COLOR_ORDER:
               cfg_in.color_order = csr_wdata[2:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // pipeline control: lane stage -> shift stage -> response register
   always_comb begin
      out_free   = ~rsp_valid | rsp_ready;
      shift_fire = shift_valid_ff & out_free;
      shift_last = (cnt_ff == lbt_pkg::LAST_BIT);
      shift_free = ~shift_valid_ff | (shift_fire & shift_last);
      shift_load = lane_valid_ff & shift_free;
      req_ready  = ~lane_valid_ff | shift_load;
      req_fire   = req_valid & req_ready;

      lane_valid_in = req_fire | (lane_valid_ff & ~shift_load);
      shift_valid_in = shift_load | (shift_valid_ff & ~(shift_fire & shift_last));
      if (shift_load) begin
         cnt_in = '0;
      end else if (shift_fire) begin
         cnt_in = cnt_ff + lbt_pkg::BIT_CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end

      ctl.capture = req_fire;
      ctl.load    = shift_load;
      ctl.shift   = shift_fire;
      ctl.last    = shift_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_count      <= lbt_pkg::CFG_COL_W'(1);
         cfg_ff.lines_per_pin     <= lbt_pkg::CFG_LINE_W'(1);
         cfg_ff.first_row_forward <= 1'b1;
         cfg_ff.brightness_offset <= 8'hFF;
         cfg_ff.color_order       <= lbt_pkg::ORDER_RGB;
         lane_valid_ff            <= 1'b0;
         shift_valid_ff           <= 1'b0;
         cnt_ff                   <= '0;
      end else begin
         cfg_ff         <= cfg_in;
         lane_valid_ff  <= lane_valid_in;
         shift_valid_ff <= shift_valid_in;
         cnt_ff         <= cnt_in;
      end
   end

   assign pixels[0] = req_data.strip0_pixel;
   assign pixels[1] = req_data.strip1_pixel;
   assign pixels[2] = req_data.strip2_pixel;
   assign pixels[3] = req_data.strip3_pixel;
   assign pixels[4] = req_data.strip4_pixel;
   assign pixels[5] = req_data.strip5_pixel;
   assign pixels[6] = req_data.strip6_pixel;
   assign pixels[7] = req_data.strip7_pixel;

   for (genvar i = 0; i < lbt_pkg::STRIP_COUNT; i++) begin : g_lane
      lbt_lane u_lane (
         .clock             (clock),
         .pixel             (pixels[i]),
         .brightness_offset (cfg_ff.brightness_offset),
         .color_order       (cfg_ff.color_order),
         .ctl               (ctl),
         .lane_bit          (lane_bits[i])
      );
   end

   lbt_position u_position (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (req_fire),
      .pos     (pos)
   );

   lbt_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_bits (lane_bits),
      .pos       (pos),
      .ctl       (ctl),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_capture_fills_lane: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> lane_valid_ff)
      else $error("accepted request did not reach the lane stage");

   a_load_restarts_count: assert property (@(posedge clock) disable iff (reset)
      shift_load |=> (shift_valid_ff && cnt_ff == '0))
      else $error("shift stage load did not restart the byte count");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      shift_valid_ff |-> (cnt_ff <= lbt_pkg::LAST_BIT))
      else $error("byte count ran past the last bit");

   a_report_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_byte) |->
         (rsp_data.next_column == '0 && rsp_data.next_row == '0 && !rsp_data.frame_done))
      else $error("position report on a byte that is not the last");
`endif

endmodule

@@ hdl/lbt_lane.sv @@
// One strip lane: dims and reorders a pixel, then shifts its color word out MSB first.
// Depends on lbt_pkg.
module lbt_lane (
   input  logic                        clock,
   input  logic [lbt_pkg::PIXEL_W-1:0] pixel,
   input  logic [lbt_pkg::BYTE_W-1:0]  brightness_offset,
   input  logic [2:0]                  color_order,
   input  lbt_pkg::ctl_type            ctl,
   output logic                        lane_bit
);

   logic [lbt_pkg::PIXEL_W-1:0] word_in;
   logic [lbt_pkg::BYTE_W-1:0]  red, green, blue;
   logic [lbt_pkg::PIXEL_W-1:0] hold_ff, hold_in;
   logic [lbt_pkg::PIXEL_W-1:0] shift_ff, shift_in;

   function automatic logic [lbt_pkg::BYTE_W-1:0] dim_byte(
      input logic [lbt_pkg::BYTE_W-1:0] value,
      input logic [lbt_pkg::BYTE_W-1:0] offset);
      dim_byte = (value == '0) ? '0 : value - offset;
   endfunction

   always_comb begin
      red   = dim_byte(pixel[23:16], brightness_offset);
      green = dim_byte(pixel[15:8], brightness_offset);
      blue  = dim_byte(pixel[7:0], brightness_offset);
      unique case (color_order)
         lbt_pkg::ORDER_RBG: word_in = {red, blue, green};
         lbt_pkg::ORDER_GRB: word_in = {green, red, blue};
         lbt_pkg::ORDER_GBR: word_in = {green, blue, red};
         lbt_pkg::ORDER_BRG: word_in = {blue, red, green};
         lbt_pkg::ORDER_BGR: word_in = {blue, green, red};
         default:            word_in = {red, green, blue};
      endcase
   end

   always_comb begin
      hold_in  = ctl.capture ? word_in : hold_ff;
      shift_in = shift_ff;
      if (ctl.load) begin
         shift_in = hold_ff;
      end else if (ctl.shift) begin
         shift_in = {shift_ff[lbt_pkg::PIXEL_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      shift_ff <= shift_in;
   end

   assign lane_bit = shift_ff[lbt_pkg::PIXEL_W-1];

endmodule

@@ hdl/lbt_position.sv @@
// Serpentine position tracker: advances column and row per accepted request.
// Depends on lbt_pkg; registers the next position for the merge stage.
module lbt_position (
   input  logic             clock,
   input  logic             reset,
   input  lbt_pkg::cfg_type cfg,
   input  logic             advance,
   output lbt_pkg::pos_type pos
);

   localparam int CW = lbt_pkg::CFG_COL_W;
   localparam int LW = lbt_pkg::CFG_LINE_W;

   logic [lbt_pkg::COL_W-1:0] col_ff, col_in;
   logic [lbt_pkg::ROW_W-1:0] row_ff, row_in;
   lbt_pkg::pos_type          pos_ff, pos_in;
   logic [CW-1:0] cols, col_cur, col_next, phys;
   logic [LW-1:0] lines, row_cur, row_next;
   logic          done, forward;

   always_comb begin
      if (cfg.column_count == '0) begin
         cols = CW'(1);
      end else if (cfg.column_count > CW'(lbt_pkg::MAX_COLUMNS)) begin
         cols = CW'(lbt_pkg::MAX_COLUMNS);
      end else begin
         cols = cfg.column_count;
      end
      if (cfg.lines_per_pin == '0) begin
         lines = LW'(1);
      end else if (cfg.lines_per_pin > LW'(lbt_pkg::MAX_LINES_PER_PIN)) begin
         lines = LW'(lbt_pkg::MAX_LINES_PER_PIN);
      end else begin
         lines = cfg.lines_per_pin;
      end

      // pull a stale position back inside a shrunk geometry
      col_cur = CW'(col_ff);
      if (col_cur > cols - CW'(1)) col_cur = cols - CW'(1);
      row_cur = LW'(row_ff);
      if (row_cur > lines - LW'(1)) row_cur = lines - LW'(1);

      col_next = col_cur + CW'(1);
      row_next = row_cur;
      done     = 1'b0;
      if (col_next >= cols) begin
         col_next = '0;
         row_next = row_cur + LW'(1);
         if (row_next >= lines) begin
            row_next = '0;
            done     = 1'b1;
         end
      end

      forward = (row_next[0] == ~cfg.first_row_forward);
      phys    = forward ? col_next : cols - CW'(1) - col_next;

      pos_in.next_column = phys[lbt_pkg::COL_W-1:0];
      pos_in.next_row    = row_next[lbt_pkg::ROW_W-1:0];
      pos_in.frame_done  = done;

      col_in = advance ? col_next[lbt_pkg::COL_W-1:0] : col_ff;
      row_in = advance ? row_next[lbt_pkg::ROW_W-1:0] : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) pos_ff <= pos_in;
   end

   assign pos = pos_ff;

endmodule

@@ hdl/lbt_merge.sv @@
// Merge stage: gathers one bit from each lane into a byte and registers the response.
// Depends on lbt_pkg; attaches the position report to the final byte.
module lbt_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lbt_pkg::STRIP_COUNT-1:0]     lane_bits,
   input  lbt_pkg::pos_type                    pos,
   input  lbt_pkg::ctl_type                    ctl,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output lbt_pkg::rsp_type                    rsp_data
);

   lbt_pkg::pos_type pos_ff, pos_in;
   logic             valid_ff, valid_in;
   lbt_pkg::rsp_type data_ff, data_in;

   always_comb begin
      pos_in   = ctl.load ? pos : pos_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.shift) begin
         valid_in            = 1'b1;
         data_in.out_byte    = lane_bits;
         data_in.last_byte   = ctl.last;
         data_in.next_column = ctl.last ? pos_ff.next_column : '0;
         data_in.next_row    = ctl.last ? pos_ff.next_row : '0;
         data_in.frame_done  = ctl.last & pos_ff.frame_done;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for led_strip_bit_transposer: predicts the 24 transposed bytes and
// the next serpentine position of every accepted request and compares them in order.
// Depends on lbt_pkg and the led_strip_bit_transposer top level.
module tb_top;
   import lbt_pkg::*;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          LONG_HOLD   = 300;
   localparam int          SETTLE      = 8;
   localparam logic [2:0]  ORDER_SPARE_6 = 3'd6;
   localparam logic [2:0]  ORDER_SPARE_7 = 3'd7;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // register copies and position as the block should hold them
   logic [CFG_COL_W-1:0]  cfg_columns = 11'd1;
   logic [CFG_LINE_W-1:0] cfg_lines   = 7'd1;
   logic                  cfg_forward = 1'b1;
   logic [BYTE_W-1:0]     cfg_offset  = 8'd255;
   logic [2:0]            cfg_order   = ORDER_RGB;
   logic [COL_W-1:0]      col_index   = '0;
   logic [ROW_W-1:0]      row_index   = '0;

   req_type pending_pixels[$];
   rsp_type expected_bytes[$];
   int      positions_open  = 0;
   int      failures        = 0;
   int      cycle_count     = 0;
   int      send_gap        = 0;
   int      rsp_stall       = 0;
   bit      req_taken       = 1'b0;
   bit      idle_on         = 1'b1;
   bit      hold_off_request = 1'b0;

   led_strip_bit_transposer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [BYTE_W-1:0] dimmed(input logic [BYTE_W-1:0] level);
      return (level == '0) ? '0 : BYTE_W'(level - cfg_offset);
   endfunction

   function automatic logic [PIXEL_W-1:0] color_word(input logic [PIXEL_W-1:0] px);
      logic [BYTE_W-1:0] r, g, b;
      r = dimmed(px[23:16]);
      g = dimmed(px[15:8]);
      b = dimmed(px[7:0]);
      case (cfg_order)
         ORDER_RBG: return {r, b, g};
         ORDER_GRB: return {g, r, b};
         ORDER_GBR: return {g, b, r};
         ORDER_BRG: return {b, r, g};
         ORDER_BGR: return {b, g, r};
         default:   return {r, g, b};
      endcase
   endfunction

   // Queue the 24 bytes of one position and advance the serpentine position.
   function automatic void transpose_position(input req_type px);
      logic [STRIP_COUNT-1:0][PIXEL_W-1:0] lanes;
      logic [PIXEL_W-1:0]                  words [STRIP_COUNT];
      int unsigned                         cols, lines, k, row, nk, nrow, phys;
      logic                                done;
      rsp_type                             r;
      lanes = px;
      cols  = (cfg_columns == 0) ? 1 : (cfg_columns > MAX_COLUMNS) ? MAX_COLUMNS : cfg_columns;
      lines = (cfg_lines == 0) ? 1 :
              (cfg_lines > MAX_LINES_PER_PIN) ? MAX_LINES_PER_PIN : cfg_lines;
      k     = (col_index > cols - 1) ? cols - 1 : col_index;
      row   = (row_index > lines - 1) ? lines - 1 : row_index;
      for (int i = 0; i < STRIP_COUNT; i++)
         words[i] = color_word(lanes[STRIP_COUNT-1-i]);
      nk   = k + 1;
      nrow = row;
      done = 1'b0;
      if (nk >= cols) begin
         nk   = 0;
         nrow = row + 1;
         if (nrow >= lines) begin
            nrow = 0;
            done = 1'b1;
         end
      end
      phys = ((nrow & 1) == (cfg_forward ? 0 : 1)) ? nk : cols - 1 - nk;
      for (int b = 0; b < PIXEL_W; b++) begin
         r = '0;
         for (int i = 0; i < STRIP_COUNT; i++)
            r.out_byte[i] = words[i][PIXEL_W-1-b];
         if (b == PIXEL_W - 1) begin
            r.last_byte   = 1'b1;
            r.next_column = COL_W'(phys);
            r.next_row    = ROW_W'(nrow);
            r.frame_done  = done;
         end
         expected_bytes.push_back(r);
      end
      col_index = COL_W'(nk);
      row_index = ROW_W'(nrow);
   endfunction

   function automatic req_type random_request();
      logic [STRIP_COUNT-1:0][PIXEL_W-1:0] lanes;
      logic [PIXEL_W-1:0]                  px;
      for (int i = 0; i < STRIP_COUNT; i++) begin
         px = PIXEL_W'($urandom);
         // force some zero and full-scale bytes
         for (int c = 0; c < 3; c++)
            case ($urandom_range(0, 7))
               0:       px[c*8 +: 8] = '0;
               1:       px[c*8 +: 8] = '1;
               default: ;
            endcase
         lanes[i] = px;
      end
      return req_type'(lanes);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_COLUMN_COUNT:      cfg_columns = CFG_COL_W'(value);
         CSR_LINES_PER_PIN:     cfg_lines   = CFG_LINE_W'(value);
         CSR_FIRST_ROW_FORWARD: cfg_forward = value[0];
         CSR_BRIGHTNESS_OFFSET: cfg_offset  = BYTE_W'(value);
         CSR_COLOR_ORDER:       cfg_order   = value[2:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned cols, input int unsigned lines,
                            input int unsigned fwd, input int unsigned offset,
                            input logic [2:0] order);
      write_reg(CSR_COLUMN_COUNT, cols);
      write_reg(CSR_LINES_PER_PIN, lines);
      write_reg(CSR_FIRST_ROW_FORWARD, fwd);
      write_reg(CSR_BRIGHTNESS_OFFSET, offset);
      write_reg(CSR_COLOR_ORDER, order);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // called right after a rising edge so the driver never races the push
   task automatic add_item(input req_type px);
      pending_pixels.push_back(px);
      positions_open++;
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (positions_open != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (req_valid && !req_taken) begin
         // hold until accepted
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
         req_valid <= 1'b1;
         req_data  <= pending_pixels.pop_front();
         if (idle_on && $urandom_range(0, 4) == 0)
            send_gap = $urandom_range(1, 19);
      end else begin
         req_valid <= 1'b0;
      end
      req_taken = 1'b0;
   end

   // response receiver
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         rsp_stall = LONG_HOLD;
      end else if (rsp_stall == 0 && idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall = $urandom_range(1, 19);
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            transpose_position(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected byte %02h last %0d col %0d row %0d done %0d",
                           rsp_data.out_byte, rsp_data.last_byte, rsp_data.next_column,
                           rsp_data.next_row, rsp_data.frame_done);
            end else begin
               want = expected_bytes.pop_front();
               if (want.last_byte)
                  positions_open--;
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.last_byte !== want.last_byte ||
                   rsp_data.next_column !== want.next_column ||
                   rsp_data.next_row !== want.next_row ||
                   rsp_data.frame_done !== want.frame_done) begin
                  failures++;
                  if (failures <= 10)
                     $display("mismatch: expected byte %02h last %0d col %0d row %0d done %0d, %s",
                              want.out_byte, want.last_byte, want.next_column,
                              want.next_row, want.frame_done,
                              $sformatf("got byte %02h last %0d col %0d row %0d done %0d",
                                        rsp_data.out_byte, rsp_data.last_byte,
                                        rsp_data.next_column, rsp_data.next_row,
                                        rsp_data.frame_done));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned cols, lines, offset;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset geometry is 1x1: every position closes the frame
      @(posedge clock);
      add_item(req_type'({8{24'h000000}}));
      add_item(req_type'({8{24'hFFFFFF}}));
      add_item(req_type'({8{24'h010101}}));
      add_item(req_type'({24'h800001, 24'h400002, 24'h200004, 24'h100008,
                          24'h080010, 24'h040020, 24'h020040, 24'h010080}));
      wait_idle();

      // 3x2 serpentine, odd rows forward, no dimming; ends mid-frame on row 1
      configure(3, 2, 0, 0, ORDER_GRB);
      @(posedge clock);
      for (int n = 0; n < 10; n++)
         add_item(random_request());
      wait_idle();

      // zero geometry clamps to one; stored row is pulled back
      configure(0, 0, 1, 1, ORDER_SPARE_6);
      @(posedge clock);
      add_item(req_type'({8{24'hFF00FF}}));
      add_item(random_request());
      wait_idle();

      // oversized geometry clamps to the maximum
      configure(2047, 127, 1, 128, ORDER_BGR);
      @(posedge clock);
      for (int n = 0; n < 3; n++)
         add_item(random_request());
      wait_idle();

      // shrink mid-row: stored column beyond the new width
      configure(2, 1, 0, 255, ORDER_SPARE_7);
      @(posedge clock);
      add_item(req_type'({8{24'h00FF00}}));
      add_item(random_request());
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         case ($urandom_range(0, 9))
            0:       cols = 0;
            1:       cols = MAX_COLUMNS;
            2:       cols = 2047;
            default: cols = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 9))
            0:       lines = 0;
            1:       lines = MAX_LINES_PER_PIN;
            2:       lines = 127;
            default: lines = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 5))
            0:       offset = 0;
            1:       offset = 255;
            default: offset = $urandom_range(0, 255);
         endcase
         configure(cols, lines, $urandom_range(0, 1), offset, 3'(p));
         @(posedge clock);
         idle_on = (p < 6) && (p % 3 != 2);
         // stall the receiver long enough to back up the input
         if (p == 1)
            hold_off_request = 1'b1;
         for (int n = 0; n < 17; n++)
            add_item(random_request());
         wait_idle();
      end

      failures += expected_bytes.size();
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
